FILE: rtl/core/bbpa_pkg.sv
package bbpa_pkg;

  // field widths of the transaction and configuration registers
  localparam int CNT_W  = 13;
  localparam int PAGE_W = 12;
  localparam int TP_W   = 13;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_INIT    = 2'd3;

  // register indexes, taken from paddr[2]
  localparam logic REG_TOTAL_PAGES    = 1'b0;
  localparam logic REG_RESERVED_PAGES = 1'b1;

  localparam logic [TP_W-1:0] TOTAL_PAGES_RESET    = 13'd4096;
  localparam logic [TP_W-1:0] RESERVED_PAGES_RESET = 13'd0;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CNT_W-1:0]  page_count;
    logic [PAGE_W-1:0] first_page;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] granted_page;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_DECODE,
    CMD_INIT_MARK,
    CMD_SC_RD,
    CMD_SC_CHK,
    CMD_ORD,
    CMD_RD,
    CMD_WR,
    CMD_ADV,
    CMD_RJ_SETUP,
    CMD_RJ_ORD,
    CMD_RJ_R0,
    CMD_RJ_R1,
    CMD_RJ_R2,
    CMD_RJ_W,
    CMD_RJ_ADV
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    in_ready;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_init;
    logic alloc_ok;
    logic clr_last;
    logic sc_found;
    logic sc_last;
    logic ord_stop;
    logic rng_empty;
    logic rng_last;
    logic adv_done;
    logic rj_skip;
    logic rj_stop;
    logic rj_empty;
    logic rj_last;
  } dp_stat_t;

endpackage

FILE: rtl/core/buddy_bitmap_page_allocator_core.sv
// buddy page allocator over per-order used bitmaps held in one RAM of
// ORDER_COUNT x ceil(MAX_PAGES/word) words; one transaction in flight at a
// time, every bitmap word marked or cleared costs a read-modify-write on the
// single RAM port pair. after reset the block clears all ORDER_COUNT*MAP_WORDS
// words (832 at defaults) with in_ready low. allocate scans the words of the
// chosen order for a free bit, then marks the run at every order; free clears
// the run at each order it reaches, then makes a rejoin pass over the aligned
// span, reading both child words and the parent word before writing the
// parent; initialize is the clearing pass plus the marking walk. the result
// sits in an output register, so the next transaction is accepted while it
// waits
module buddy_bitmap_page_allocator_core import bbpa_pkg::*; #(
  parameter int MAX_PAGES     = 4096,
  parameter int ORDER_COUNT   = 13,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input transaction
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  // result transaction
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TP_W-1:0] total_pages_r;
  logic [TP_W-1:0] reserved_pages_r;
  logic            cfg_wr;
  logic            out_free;
  ctrl_t           ctl;
  dp_stat_t        stat;
  out_t            result;

  // configuration registers, one word per register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages_r    <= TOTAL_PAGES_RESET;
      reserved_pages_r <= RESERVED_PAGES_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TOTAL_PAGES:    total_pages_r    <= pwdata[TP_W-1:0];
        REG_RESERVED_PAGES: reserved_pages_r <= pwdata[TP_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_RESERVED_PAGES) ? 32'(reserved_pages_r)
                                                   : 32'(total_pages_r);

  // output register decouples the result from the next transaction
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) out_item <= result;
  end

  assign in_ready = ctl.in_ready;

  // sequencer
  bbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // bitmap datapath with the map RAM
  bbpa_dp #(
    .MAX_PAGES     (MAX_PAGES),
    .ORDER_COUNT   (ORDER_COUNT),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctl.cmd),
    .in_item        (in_item),
    .total_pages    (total_pages_r),
    .reserved_pages (reserved_pages_r),
    .stat           (stat),
    .result         (result)
  );

`ifndef SYNTH
  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // accepting a transaction and finishing one never coincide
  a_accept_vs_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !ctl.out_load)
    else $error("accept while finishing");

  // total_pages only changes through a write
  a_cfg_stable: assert property (@(posedge clk) disable iff (rst)
    !$stable(total_pages_r) |-> $past(cfg_wr))
    else $error("total_pages changed without a write");

  // a loaded result is shown in the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid)
    else $error("loaded result not valid");
`endif

endmodule

FILE: rtl/core/bbpa_ram.sv
module bbpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 832,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bbpa_dp.sv
module bbpa_dp import bbpa_pkg::*; #(
  parameter int MAX_PAGES     = 4096,
  parameter int ORDER_COUNT   = 13,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  dp_cmd_e         cmd,
  input  in_t             in_item,
  input  logic [TP_W-1:0] total_pages,
  input  logic [TP_W-1:0] reserved_pages,
  output dp_stat_t        stat,
  output out_t            result
);

  localparam int WL        = $clog2(MAP_WORD_BITS);
  localparam int W         = 1 << WL;
  localparam int MAP_WORDS = (MAX_PAGES + W - 1) / W;
  localparam int DEPTH     = ORDER_COUNT * MAP_WORDS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(MAX_PAGES + 1);
  localparam int NB        = (PW > ORDER_COUNT) ? PW : ORDER_COUNT;
  localparam int NW        = ((NB > CNT_W) ? NB : CNT_W) + 2;
  localparam int KW        = $clog2(ORDER_COUNT);
  localparam logic [NW-1:0] SPAN   = NW'(1) << (ORDER_COUNT - 1);
  localparam logic [KW-1:0] K_LAST = KW'(ORDER_COUNT - 1);

  logic [1:0]        op;
  logic [NW-1:0]     cnt, first, s, ln, lo, hi;
  logic [KW-1:0]     k, kp1, ka;
  logic [WIW-1:0]    w, ci0, ci1;
  logic [W-1:0]      c0, c1;
  logic [AW-1:0]     clr_addr;
  logic [1:0]        res_status;
  logic [PAGE_W-1:0] res_page;

  logic [NW-1:0]     tp, lim_k, lim_k1, base, cbase, e_sum, e;
  logic [NW-1:0]     plo, phi1, pe, lo_n, hi_n, qsum, hraw, cap, sc_start;
  logic [NW-1:0]     ln_mark, ln_free;
  logic [WIW:0]      cw0, cw1;
  logic [W-1:0]      rdata, wdata, m_rng, m_val, freev, m_c0, m_c1, m_par, pfree;
  logic [2*W-1:0]    cu;
  logic [WL-1:0]     sc_j;
  logic              kok;
  logic              we;
  logic [AW-1:0]     waddr, raddr;

  function automatic logic [AW-1:0] addr_of(input logic [KW-1:0] kk,
                                            input logic [WIW-1:0] ww);
    return AW'(32'(kk) * MAP_WORDS + 32'(ww));
  endfunction

  // bits [lo_i, hx_i) of the word whose first bit index is b
  function automatic logic [W-1:0] rmask(input logic [NW-1:0] b,
                                         input logic [NW-1:0] lo_i,
                                         input logic [NW-1:0] hx_i);
    logic [NW-1:0] a, z;
    logic [W:0]    ma, mb;
    a = (lo_i > b) ? lo_i - b : '0;
    z = (hx_i > b) ? hx_i - b : '0;
    if (a > NW'(W)) a = NW'(W);
    if (z > NW'(W)) z = NW'(W);
    ma = {(W+1){1'b1}} << a;
    mb = {(W+1){1'b1}} << z;
    return W'(ma & ~mb);
  endfunction

  assign tp     = (NW'(total_pages) > NW'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(total_pages);
  assign kp1    = KW'(32'(k) + 1);
  assign lim_k  = tp >> k;
  assign lim_k1 = tp >> (32'(k) + 1);
  assign base   = NW'(w) << WL;
  assign cbase  = base << 1;

  // range walk
  assign e_sum = s + ln;
  assign e     = (e_sum > lim_k) ? lim_k : e_sum;
  assign m_rng = rmask(base, s, e);
  assign ln_mark = (ln + NW'(1)) >> 1;
  assign ln_free = ln >> 1;

  // scan
  assign m_val = rmask(base, '0, lim_k);
  assign freev = ~rdata & m_val;

  always_comb begin
    sc_j = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (freev[j]) sc_j = WL'(j);
    end
  end

  assign sc_start = (base + NW'(sc_j)) << k;

  // smallest order that covers the request
  always_comb begin
    ka  = '0;
    kok = 1'b0;
    for (int q = ORDER_COUNT - 1; q >= 0; q--) begin
      if ((NW'(1) << q) >= cnt) begin
        ka  = KW'(q);
        kok = 1'b1;
      end
    end
  end

  // rejoin span
  assign lo_n = (first >> (ORDER_COUNT - 1)) << (ORDER_COUNT - 1);
  assign qsum = first + cnt + (SPAN - NW'(1));
  assign hraw = (qsum >> (ORDER_COUNT - 1)) << (ORDER_COUNT - 1);
  assign cap  = tp - NW'(1);
  assign hi_n = (hraw == '0 || (hraw - NW'(1)) > cap) ? cap : hraw - NW'(1);

  assign plo  = lo >> 1;
  assign phi1 = (hi >> 1) + NW'(1);
  assign pe   = (phi1 > lim_k1) ? lim_k1 : phi1;

  assign cw0 = {1'b0, w} << 1;
  assign cw1 = cw0 + (WIW+1)'(1);
  assign ci0 = (32'(cw0) < MAP_WORDS) ? WIW'(cw0) : '0;
  assign ci1 = (32'(cw1) < MAP_WORDS) ? WIW'(cw1) : '0;

  assign m_c0  = rmask(cbase, '0, lim_k);
  assign m_c1  = rmask(cbase + NW'(W), '0, lim_k);
  assign cu    = {c1 & m_c1, c0 & m_c0};
  assign m_par = rmask(base, plo, pe);

  always_comb begin
    for (int j = 0; j < W; j++) begin
      pfree[j] = ~(cu[2*j] | cu[2*j+1]);
    end
  end

  // status to the controller
  always_comb begin
    stat.is_alloc  = (op == OP_ALLOC);
    stat.is_free   = (op == OP_FREE);
    stat.is_init   = (op == OP_INIT);
    stat.alloc_ok  = kok && ((tp >> ka) != '0);
    stat.clr_last  = (32'(clr_addr) == DEPTH - 1);
    stat.sc_found  = |freev;
    stat.sc_last   = (w == WIW'((lim_k - NW'(1)) >> WL));
    stat.ord_stop  = (op == OP_FREE) && (lim_k == '0);
    stat.rng_empty = (s >= e);
    stat.rng_last  = (w == WIW'((e - NW'(1)) >> WL));
    stat.adv_done  = (k == K_LAST) || ((op == OP_FREE) && (ln_free == '0));
    stat.rj_skip   = (tp == '0) || (lo_n > hi_n);
    stat.rj_stop   = (k == K_LAST) || (lim_k1 == '0);
    stat.rj_empty  = (plo >= pe);
    stat.rj_last   = (w == WIW'((pe - NW'(1)) >> WL));
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = addr_of(k, w);
    raddr = addr_of(k, w);
    wdata = rdata | m_rng;
    case (cmd)
      CMD_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      CMD_WR: begin
        we    = 1'b1;
        wdata = (op == OP_FREE) ? (rdata & ~m_rng) : (rdata | m_rng);
      end
      CMD_RJ_R0: raddr = addr_of(k, ci0);
      CMD_RJ_R1: raddr = addr_of(k, ci1);
      CMD_RJ_R2: raddr = addr_of(kp1, w);
      CMD_RJ_W: begin
        we    = 1'b1;
        waddr = addr_of(kp1, w);
        wdata = rdata & ~(pfree & m_par);
      end
      default: ;
    endcase
  end

  bbpa_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else begin
      case (cmd)
        CMD_CLEAR: clr_addr <= stat.clr_last ? '0 : clr_addr + AW'(1);
        CMD_LOAD: begin
          op    <= in_item.operation;
          cnt   <= NW'(in_item.page_count);
          first <= NW'(in_item.first_page);
        end
        CMD_DECODE: begin
          k        <= (op == OP_ALLOC) ? ka : '0;
          s        <= first;
          ln       <= cnt;
          w        <= '0;
          res_page <= '0;
          if (op == OP_FREE) res_status <= ST_FREED;
          else if (op == OP_INIT) res_status <= ST_INIT;
          else res_status <= ST_NOSPACE;
        end
        CMD_INIT_MARK: begin
          k  <= '0;
          s  <= '0;
          ln <= NW'(reserved_pages);
        end
        CMD_ORD: w <= WIW'(s >> WL);
        CMD_WR:  w <= w + WIW'(1);
        CMD_ADV: begin
          s  <= s >> 1;
          ln <= (op == OP_FREE) ? ln_free : ln_mark;
          k  <= kp1;
        end
        CMD_SC_CHK: begin
          if (stat.sc_found) begin
            s          <= sc_start;
            ln         <= cnt;
            k          <= '0;
            res_status <= ST_GRANTED;
            res_page   <= sc_start[PAGE_W-1:0];
          end else begin
            w <= w + WIW'(1);
          end
        end
        CMD_RJ_SETUP: begin
          lo <= lo_n;
          hi <= hi_n;
          k  <= '0;
        end
        CMD_RJ_ORD: w  <= WIW'(plo >> WL);
        CMD_RJ_R1:  c0 <= rdata;
        CMD_RJ_R2:  c1 <= rdata;
        CMD_RJ_W:   w  <= w + WIW'(1);
        CMD_RJ_ADV: begin
          lo <= lo >> 1;
          hi <= hi >> 1;
          k  <= kp1;
        end
        default: ;
      endcase
    end
  end

  assign result.status       = res_status;
  assign result.granted_page = res_page;

endmodule

FILE: rtl/core/bbpa_ctrl.sv
module bbpa_ctrl import bbpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  input  logic     in_valid,
  input  logic     out_free,
  output ctrl_t    ctl
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_INIT, S_SC_RD, S_SC_CHK,
    S_ORD, S_RD, S_WR, S_ADV,
    S_RJ_SETUP, S_RJ_ORD, S_RJ_R0, S_RJ_R1, S_RJ_R2, S_RJ_W, S_RJ_ADV,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   boot;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (stat.clr_last) state_next = boot ? S_IDLE : S_INIT;
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (stat.is_alloc) state_next = stat.alloc_ok ? S_SC_RD : S_FINISH;
        else if (stat.is_free) state_next = S_ORD;
        else if (stat.is_init) state_next = S_CLEAR;
        else state_next = S_FINISH;
      end
      S_INIT:     state_next = S_ORD;
      S_SC_RD:    state_next = S_SC_CHK;
      S_SC_CHK: begin
        if (stat.sc_found) state_next = S_ORD;
        else if (stat.sc_last) state_next = S_FINISH;
        else state_next = S_SC_RD;
      end
      S_ORD: begin
        if (stat.ord_stop) state_next = S_RJ_SETUP;
        else if (stat.rng_empty) state_next = S_ADV;
        else state_next = S_RD;
      end
      S_RD:       state_next = S_WR;
      S_WR:       state_next = stat.rng_last ? S_ADV : S_RD;
      S_ADV: begin
        if (!stat.adv_done) state_next = S_ORD;
        else state_next = stat.is_free ? S_RJ_SETUP : S_FINISH;
      end
      S_RJ_SETUP: state_next = stat.rj_skip ? S_FINISH : S_RJ_ORD;
      S_RJ_ORD: begin
        if (stat.rj_stop) state_next = S_FINISH;
        else if (stat.rj_empty) state_next = S_RJ_ADV;
        else state_next = S_RJ_R0;
      end
      S_RJ_R0:    state_next = S_RJ_R1;
      S_RJ_R1:    state_next = S_RJ_R2;
      S_RJ_R2:    state_next = S_RJ_W;
      S_RJ_W:     state_next = stat.rj_last ? S_RJ_ADV : S_RJ_R0;
      S_RJ_ADV:   state_next = S_RJ_ORD;
      S_FINISH:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_CLEAR && stat.clr_last) boot <= 1'b0;
    end
  end

  always_comb begin
    ctl.in_ready = (state == S_IDLE);
    ctl.out_load = (state == S_FINISH) && out_free;
    case (state)
      S_CLEAR:    ctl.cmd = CMD_CLEAR;
      S_IDLE:     ctl.cmd = in_valid ? CMD_LOAD : CMD_NONE;
      S_DECODE:   ctl.cmd = CMD_DECODE;
      S_INIT:     ctl.cmd = CMD_INIT_MARK;
      S_SC_RD:    ctl.cmd = CMD_SC_RD;
      S_SC_CHK:   ctl.cmd = CMD_SC_CHK;
      S_ORD:      ctl.cmd = CMD_ORD;
      S_RD:       ctl.cmd = CMD_RD;
      S_WR:       ctl.cmd = CMD_WR;
      S_ADV:      ctl.cmd = CMD_ADV;
      S_RJ_SETUP: ctl.cmd = CMD_RJ_SETUP;
      S_RJ_ORD:   ctl.cmd = CMD_RJ_ORD;
      S_RJ_R0:    ctl.cmd = CMD_RJ_R0;
      S_RJ_R1:    ctl.cmd = CMD_RJ_R1;
      S_RJ_R2:    ctl.cmd = CMD_RJ_R2;
      S_RJ_W:     ctl.cmd = CMD_RJ_W;
      S_RJ_ADV:   ctl.cmd = CMD_RJ_ADV;
      default:    ctl.cmd = CMD_NONE;
    endcase
  end

endmodule

FILE: tb/tb_top.sv
class alloc_scoreboard;
  localparam int ORDERS = 13;
  localparam int PAGES  = 4096;

  bit [PAGES-1:0] used_map [ORDERS];
  int unsigned    total_pages;
  int unsigned    reserved_pages;
  bbpa_pkg::out_t expected_q [$];
  int unsigned    live_first [$];
  int unsigned    live_count [$];
  int             errors;

  function new();
    foreach (used_map[k]) used_map[k] = '0;
    total_pages    = 4096;
    reserved_pages = 0;
    errors         = 0;
  endfunction

  function int unsigned bits_at(int unsigned k);
    int unsigned t;
    t = (total_pages > PAGES) ? PAGES : total_pages;
    return t >> k;
  endfunction

  function bit is_used(int unsigned k, int unsigned i);
    if (i >= bits_at(k)) return 1'b0;
    return used_map[k][i];
  endfunction

  function void put_bit(int unsigned k, int unsigned i, bit v);
    if (i >= bits_at(k)) return;
    used_map[k][i] = v;
  endfunction

  function void mark_run(int unsigned start, int unsigned len);
    int unsigned stop;
    for (int unsigned k = 0; k < ORDERS; k++) begin
      stop = start + len;
      if (stop > bits_at(k)) stop = bits_at(k);
      for (int unsigned n = start; n < stop; n++) put_bit(k, n, 1'b1);
      start = start / 2;
      len   = (len + 1) / 2;
    end
  endfunction

  function void rejoin_pass(int unsigned lo, int unsigned hi);
    for (int unsigned k = 0; k + 1 < ORDERS; k++) begin
      if (bits_at(k + 1) == 0) break;
      for (int unsigned b = lo; b <= hi; b += 2)
        if (!is_used(k, b) && !is_used(k, b + 1)) put_bit(k + 1, b / 2, 1'b0);
      lo = lo / 2;
      hi = hi / 2;
    end
  endfunction

  function void free_run(int unsigned first, int unsigned len);
    int unsigned span, start, cnt, stop, lo, hi, cap;
    span  = PAGES;
    start = first;
    cnt   = len;
    for (int unsigned k = 0; k < ORDERS; k++) begin
      if (bits_at(k) == 0) break;
      stop = start + cnt;
      if (stop > bits_at(k)) stop = bits_at(k);
      for (int unsigned n = start; n < stop; n++) put_bit(k, n, 1'b0);
      start = start / 2;
      cnt   = cnt / 2;
      if (cnt == 0) break;
    end
    if (bits_at(0) == 0) return;
    lo  = (first / span) * span;
    hi  = ((first + len + (span - 1)) / span) * span - 1;
    cap = bits_at(0) - 1;
    if (hi > cap) hi = cap;
    if (lo <= hi) rejoin_pass(lo, hi);
  endfunction

  function void write_reg(bit idx, int unsigned value);
    if (idx == bbpa_pkg::REG_TOTAL_PAGES) total_pages = value & 32'h1FFF;
    else reserved_pages = value & 32'h1FFF;
  endfunction

  function void note_input(bbpa_pkg::in_t it);
    bbpa_pkg::out_t res;
    int unsigned k, cnt, start;
    res.status       = bbpa_pkg::ST_NOSPACE;
    res.granted_page = '0;
    cnt = it.page_count;
    case (it.operation)
      bbpa_pkg::OP_ALLOC: begin
        for (k = 0; k < ORDERS; k++)
          if ((32'd1 << k) >= cnt) break;
        if (k < ORDERS) begin
          for (int unsigned i = 0; i < bits_at(k); i++) begin
            if (!is_used(k, i)) begin
              start = i << k;
              mark_run(start, cnt);
              res.status       = bbpa_pkg::ST_GRANTED;
              res.granted_page = start[11:0];
              if (cnt > 0) begin
                live_first.push_back(start);
                live_count.push_back(cnt);
              end
              break;
            end
          end
        end
      end
      bbpa_pkg::OP_FREE: begin
        free_run(it.first_page, cnt);
        res.status = bbpa_pkg::ST_FREED;
      end
      bbpa_pkg::OP_INIT: begin
        foreach (used_map[j]) used_map[j] = '0;
        mark_run(0, reserved_pages);
        live_first.delete();
        live_count.delete();
        res.status = bbpa_pkg::ST_INIT;
      end
      default: ;
    endcase
    expected_q.push_back(res);
  endfunction

  function void check_result(bbpa_pkg::out_t got);
    bbpa_pkg::out_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: status %0d page %0d",
             got.status, got.granted_page);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, actual %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.granted_page !== exp_r.granted_page) begin
      $error("granted_page: expected %0d, actual %0d",
             exp_r.granted_page, got.granted_page);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  import bbpa_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  // operation code with no defined meaning
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard sb = new();

  // calm: no idling on either side (end of the run)
  bit calm = 1'b0;
  int hold_seq = 0;
  int hold_seen = 0;
  int rx_cnt = 0;
  int quiet_cycles = 0;

  buddy_bitmap_page_allocator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // result side: check every accepted transaction, idle in random bursts,
  // and honor a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_item);
      if (hold_seq != hold_seen) begin
        hold_seen <= hold_seq;
        out_ready <= 1'b0;
        rx_cnt    <= HOLD_CYCLES;
      end else if (rx_cnt > 0) begin
        rx_cnt <= rx_cnt - 1;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        rx_cnt    <= $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
        rx_cnt    <= $urandom_range(0, 30);
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // offer one transaction, hold it until accepted, then maybe idle a burst
  task automatic send_op(in_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [1:0] op, int unsigned cnt, int unsigned first);
    in_t it;
    it.operation  = op;
    it.page_count = cnt[CNT_W-1:0];
    it.first_page = first[PAGE_W-1:0];
    send_op(it);
  endtask

  // drop valid and wait until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup cycle then access cycle; written at the edge with pready high
  task automatic reg_write(bit idx, int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly alloc and matching frees of live runs, with noise on top
  task automatic random_op();
    int r, j;
    int unsigned cnt;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      case ($urandom_range(0, 19))
        0:       cnt = 0;
        1:       cnt = $urandom_range(4097, 8191);
        2, 3:    cnt = $urandom_range(1, 4096);
        4, 5, 6: cnt = $urandom_range(17, 300);
        default: cnt = $urandom_range(1, 16);
      endcase
      send_fields(OP_ALLOC, cnt, $urandom_range(0, 4095));
    end else if (r < 82 && sb.live_first.size() > 0) begin
      j = $urandom_range(0, sb.live_first.size() - 1);
      send_fields(OP_FREE, sb.live_count[j], sb.live_first[j]);
      sb.live_first.delete(j);
      sb.live_count.delete(j);
    end else if (r < 85) begin
      send_fields(OP_INIT, $urandom_range(0, 8191), $urandom_range(0, 4095));
    end else if (r < 87) begin
      send_fields(OP_UNDEFINED, $urandom_range(0, 8191), $urandom_range(0, 4095));
    end else if (r < 94) begin
      send_fields(OP_FREE, $urandom_range(0, 32), $urandom_range(0, 4095));
    end else begin
      send_fields(OP_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095));
    end
  endtask

  int unsigned phase_total [8] = '{4096, 1, 0, 4096, 5000, 8191, 1000, 4096};
  int unsigned phase_resv  [8] = '{0, 0, 300, 4096, 17, 8191, 37, 100};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, each operation, the special cases
    send_fields(OP_ALLOC, 1, 0);
    send_fields(OP_ALLOC, 0, 4095);         // zero count grants, marks nothing
    send_fields(OP_ALLOC, 3, 0);            // rounds up to order 2
    send_fields(OP_ALLOC, 4096, 0);         // whole map, no room left
    send_fields(OP_ALLOC, 4097, 0);         // larger than the top order
    send_fields(OP_ALLOC, 8191, 4095);
    send_fields(OP_FREE, 0, 0);             // nothing cleared, rejoin still runs
    send_fields(OP_FREE, 1, 0);
    send_fields(OP_FREE, 8191, 4095);       // run past the end
    send_fields(OP_FREE, 64, 2048);         // never allocated
    send_fields(OP_ALLOC, 4096, 0);
    send_fields(OP_UNDEFINED, 8191, 4095);  // unknown operation
    send_fields(OP_INIT, 0, 0);
    send_fields(OP_ALLOC, 2048, 0);
    send_fields(OP_ALLOC, 2048, 0);
    send_fields(OP_ALLOC, 1, 0);            // full map
    send_fields(OP_FREE, 4096, 0);
    send_fields(OP_ALLOC, 2, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      reg_write(REG_TOTAL_PAGES, phase_total[p]);
      reg_write(REG_RESERVED_PAGES, phase_resv[p]);
      // total change without initialize: old maps reread at new sizes
      if (p != 5) send_fields(OP_INIT, 0, 0);
      if (p == 7) calm = 1'b1;
      for (int n = 0; n < 210; n++) begin
        if (p == 1 && n == 60) begin
          // result side holds off while transactions keep coming
          hold_seq <= hold_seq + 1;
          for (int m = 0; m < 20; m++) send_fields(OP_ALLOC, 1, 0);
        end
        if (p == 3 && n == 100) begin
          // sender waits for every outstanding result
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending() > 0) @(posedge clk);
        end
        random_op();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/bbpa_pkg.sv
rtl/core/bbpa_ram.sv
rtl/core/bbpa_dp.sv
rtl/core/bbpa_ctrl.sv
rtl/core/buddy_bitmap_page_allocator_core.sv
tb/tb_top.sv
